// ----- sv/lfa_pkg.sv -----
// Shared types, command codes and neighbour tables for the life automaton engine.
package lfa_pkg;

    localparam int COORD_IN_W = 6;
    localparam int GRID_W     = 7;
    localparam int CNT_W      = 4;
    localparam int CHG_W      = 13;
    localparam int CELL_W     = CNT_W + 1;

    // Rule B3/S23
    localparam logic [CNT_W-1:0] CNT_SURVIVE = 4'd2;
    localparam logic [CNT_W-1:0] CNT_BIRTH   = 4'd3;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_STEP  = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd_code;

    typedef struct packed {
        t_cmd_code                cmd;
        logic [COORD_IN_W-1:0]    col;
        logic [COORD_IN_W-1:0]    row;
        logic                     alive_in;
    } t_item;

    typedef struct packed {
        logic                     cell_alive;
        logic [CNT_W-1:0]         neighbour_count;
        logic [CHG_W-1:0]         changed_count;
        logic                     out_of_range;
    } t_result;

    // Neighbour k picks row and column offsets (0 minus one, 1 same, 2 plus one)
    localparam logic [1:0] NB_DR [8] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2};
    localparam logic [1:0] NB_DC [8] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd2, 2'd0, 2'd1, 2'd2};

endpackage

// ----- sv/lfa_ram.sv -----
// Single write port, single registered read port cell memory.
module lfa_ram #(
    parameter int W  = 5,
    parameter int AW = 12
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [2**AW];
    logic [W-1:0] r_rdata;

    // Write one word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Register the read word
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/lfa_seq.sv -----
// Command sequencer: clear sweep, cell access, two-pass generation step with
// a shared neighbour-count incrementer/decrementer.
module lfa_seq #(
    parameter int MAX_GRID = 64
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_cfg_clear,
    input  logic [$clog2(MAX_GRID+1)-1:0]             i_n,
    input  logic                                      i_start,
    input  lfa_pkg::t_item                            i_item,
    output logic                                      o_idle,
    output logic                                      o_res_valid,
    input  logic                                      i_res_take,
    output lfa_pkg::t_result                          o_res
);
    import lfa_pkg::*;

    localparam int CW = $clog2(MAX_GRID);
    localparam int NW = $clog2(MAX_GRID + 1);
    localparam int AW = 2 * CW;
    localparam int XW = (CW > COORD_IN_W) ? CW : COORD_IN_W;
    localparam int EW = (NW > XW) ? NW : XW;

    typedef enum logic [8:0] {
        S_CLR  = 9'b0_0000_0001,
        S_IDLE = 9'b0_0000_0010,
        S_RDW  = 9'b0_0000_0100,
        S_OWN  = 9'b0_0000_1000,
        S_NRD  = 9'b0_0001_0000,
        S_NWR  = 9'b0_0010_0000,
        S_P1   = 9'b0_0100_0000,
        S_P2   = 9'b0_1000_0000,
        S_DONE = 9'b1_0000_0000
    } t_state;

    t_state              r_state;
    t_cmd_code           r_cmd;
    logic                r_want;
    logic [CW-1:0]       r_r, r_c;
    logic [2:0]          r_k;
    logic [CW-1:0]       r_rows [3];
    logic [CW-1:0]       r_cols [3];
    logic                r_inc;
    logic [AW-1:0]       r_clr_addr;
    logic                r_clr_res;
    logic                r_p1v;
    logic [AW-1:0]       r_p1a;
    logic                r_scan_done;
    logic [CHG_W-1:0]    r_changed;
    logic                r_alive;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_oor;

    logic [EW-1:0]       col_e, row_e, n_e;
    logic                in_oor;
    logic [CW-1:0]       in_c, in_r;
    logic [NW-1:0]       n_m1;
    logic [CW-1:0]       last_c;
    logic                at_row_end, at_last;
    logic [CW-1:0]       c_prev, c_next, r_prev, r_next;
    logic [AW-1:0]       own_addr, nb_addr, m_raddr;
    logic                m_we;
    logic [AW-1:0]       m_waddr;
    logic [CELL_W-1:0]   m_wdata, m_rdata;
    logic [0:0]          f_rdata;
    logic                rd_alive;
    logic [CNT_W-1:0]    rd_cnt, cnt_adj;
    logic                act, inc;
    logic                p1_flag;

    // Range check and coordinate narrowing of the incoming word
    assign col_e  = EW'(i_item.col);
    assign row_e  = EW'(i_item.row);
    assign n_e    = EW'(i_n);
    assign in_oor = (col_e >= n_e) || (row_e >= n_e);
    assign in_c   = col_e[CW-1:0];
    assign in_r   = row_e[CW-1:0];

    // Torus wrap helpers
    assign n_m1       = i_n - NW'(1);
    assign last_c     = n_m1[CW-1:0];
    assign at_row_end = (r_c == last_c);
    assign at_last    = at_row_end && (r_r == last_c);
    assign c_prev     = (r_c == '0) ? last_c : r_c - CW'(1);
    assign c_next     = at_row_end ? '0 : r_c + CW'(1);
    assign r_prev     = (r_r == '0) ? last_c : r_r - CW'(1);
    assign r_next     = (r_r == last_c) ? '0 : r_r + CW'(1);

    assign own_addr = {r_r, r_c};
    assign nb_addr  = {r_rows[NB_DR[r_k]], r_cols[NB_DC[r_k]]};

    assign rd_alive = m_rdata[CELL_W-1];
    assign rd_cnt   = m_rdata[CNT_W-1:0];
    // Shared incrementer/decrementer for neighbour counts
    assign cnt_adj  = r_inc ? rd_cnt + CNT_W'(1) : rd_cnt - CNT_W'(1);

    assign act = (r_cmd == CMD_WRITE) ? (rd_alive != r_want) : f_rdata[0];
    assign inc = (r_cmd == CMD_WRITE) ? r_want : !rd_alive;

    assign p1_flag = rd_alive ? ((rd_cnt != CNT_SURVIVE) && (rd_cnt != CNT_BIRTH))
                              : (rd_cnt == CNT_BIRTH);

    // Read address select
    always_comb begin
        case (r_state)
            S_IDLE:  m_raddr = {in_r, in_c};
            S_NRD:   m_raddr = nb_addr;
            default: m_raddr = own_addr;
        endcase
    end

    // Cell store write select
    always_comb begin
        m_we    = 1'b0;
        m_waddr = own_addr;
        m_wdata = '0;
        case (r_state)
            S_CLR: begin
                m_we    = 1'b1;
                m_waddr = r_clr_addr;
            end
            S_OWN: begin
                m_we    = act;
                m_wdata = {inc, rd_cnt};
            end
            S_NWR: begin
                m_we    = 1'b1;
                m_waddr = nb_addr;
                m_wdata = {rd_alive, cnt_adj};
            end
            default: m_we = 1'b0;
        endcase
    end

    lfa_ram #(.W(CELL_W), .AW(AW)) u_cells (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (m_waddr),
        .i_wdata (m_wdata),
        .i_raddr (m_raddr),
        .o_rdata (m_rdata)
    );

    lfa_ram #(.W(1), .AW(AW)) u_flags (
        .i_clk   (i_clk),
        .i_we    (r_p1v),
        .i_waddr (r_p1a),
        .i_wdata (p1_flag),
        .i_raddr (m_raddr),
        .o_rdata (f_rdata)
    );

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_clear) begin
            r_state     <= S_CLR;
            r_clr_addr  <= '0;
            r_clr_res   <= 1'b0;
            r_p1v       <= 1'b0;
            r_scan_done <= 1'b0;
        end else begin
            r_p1v <= (r_state == S_P1) && !r_scan_done;
            case (r_state)
                S_CLR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == {AW{1'b1}}) begin
                        r_state <= r_clr_res ? S_DONE : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_start) begin
                        r_cmd     <= i_item.cmd;
                        r_want    <= i_item.alive_in;
                        r_r       <= in_r;
                        r_c       <= in_c;
                        r_changed <= '0;
                        r_alive   <= 1'b0;
                        r_cnt     <= '0;
                        r_oor     <= 1'b0;
                        case (i_item.cmd)
                            CMD_WRITE, CMD_READ: begin
                                if (in_oor) begin
                                    r_oor   <= 1'b1;
                                    r_state <= S_DONE;
                                end else begin
                                    r_state <= (i_item.cmd == CMD_READ) ? S_RDW : S_OWN;
                                end
                            end
                            CMD_STEP: begin
                                r_r         <= '0;
                                r_c         <= '0;
                                r_scan_done <= 1'b0;
                                r_state     <= S_P1;
                            end
                            default: begin
                                r_clr_addr <= '0;
                                r_clr_res  <= 1'b1;
                                r_state    <= S_CLR;
                            end
                        endcase
                    end
                end
                S_RDW: begin
                    r_alive <= rd_alive;
                    r_cnt   <= rd_cnt;
                    r_state <= S_DONE;
                end
                S_P1: begin
                    // Issue one cell a cycle, judge it in the following cycle
                    if (!r_scan_done) begin
                        r_p1a <= own_addr;
                        r_c   <= c_next;
                        if (at_row_end) begin
                            r_r <= r_next;
                        end
                        if (at_last) begin
                            r_scan_done <= 1'b1;
                        end
                    end
                    if (r_p1v && p1_flag && (r_changed != {CHG_W{1'b1}})) begin
                        r_changed <= r_changed + CHG_W'(1);
                    end
                    if (r_scan_done && !r_p1v) begin
                        r_r     <= '0;
                        r_c     <= '0;
                        r_state <= S_P2;
                    end
                end
                S_P2: begin
                    r_state <= S_OWN;
                end
                S_OWN: begin
                    if (act) begin
                        r_inc   <= inc;
                        r_rows  <= '{r_prev, r_r, r_next};
                        r_cols  <= '{c_prev, r_c, c_next};
                        r_k     <= '0;
                        r_state <= S_NRD;
                    end else if (r_cmd == CMD_WRITE || at_last) begin
                        r_state <= S_DONE;
                    end else begin
                        r_c     <= c_next;
                        r_r     <= at_row_end ? r_next : r_r;
                        r_state <= S_P2;
                    end
                end
                S_NRD: begin
                    r_state <= S_NWR;
                end
                S_NWR: begin
                    if (r_k != 3'd7) begin
                        r_k     <= r_k + 3'd1;
                        r_state <= S_NRD;
                    end else if (r_cmd == CMD_WRITE || at_last) begin
                        r_state <= S_DONE;
                    end else begin
                        r_c     <= c_next;
                        r_r     <= at_row_end ? r_next : r_r;
                        r_state <= S_P2;
                    end
                end
                S_DONE: begin
                    if (i_res_take) begin
                        r_clr_res <= 1'b0;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_CLR;
            endcase
        end
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = '{cell_alive:      r_alive,
                           neighbour_count: r_cnt,
                           changed_count:   r_changed,
                           out_of_range:    r_oor};

`ifndef SYNTHESIS
    // A step command always starts with the judging pass
    a_step_enters_p1: assert property (@(posedge i_clk) disable iff (!i_rst_n || i_cfg_clear)
        (r_state == S_IDLE && i_start && i_item.cmd == CMD_STEP) |=> (r_state == S_P1))
        else $error("step did not enter judging pass");

    // Walked cell stays inside the grid
    a_cell_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OWN || r_state == S_NWR) |-> (EW'(r_c) < n_e && EW'(r_r) < n_e))
        else $error("walked cell outside grid");

    // A neighbour update never lands on the cell itself
    a_nb_not_self: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NWR) |-> (nb_addr != own_addr))
        else $error("neighbour address equals own cell");
`endif

endmodule

// ----- sv/life_automaton_torus.sv -----
// Life automaton engine on a square toroidal grid: reads, writes and steps
// are walked by the sequencer over one cell memory read port, a step also
// updating the neighbours of every changed cell; clear and every grid_size
// write sweep all 2**(2*clog2(MAX_GRID)) cells one per cycle (4096 at 64) with
// the input not ready; after reset the same sweep runs before the first word.
module life_automaton_torus #(
    parameter int MAX_GRID = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // col[5:0], row[11:6], alive_in[12], zero fill
    input  logic [1:0]  s_axis_tuser,   // command[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // cell_alive[0], neighbour_count[4:1],
                                        // changed_count[17:5], zero fill
    output logic [0:0]  m_axis_tuser,   // out_of_range[0]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_cfg_data      // grid_size
);
    import lfa_pkg::*;

    localparam int NW = $clog2(MAX_GRID + 1);
    localparam int GW = (NW > GRID_W) ? NW : GRID_W;

    logic [GRID_W-1:0] r_grid;
    logic [GW-1:0]     g_e, g_cl;
    logic [NW-1:0]     n_eff;
    logic              cfg_wr, idle, start, res_valid, take;
    t_item             item;
    t_result           res, r_out;
    logic              r_mv;

    // Grid size register
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid <= GRID_W'(64);
        end else if (cfg_wr) begin
            r_grid <= i_cfg_data;
        end
    end

    // Clamp grid size into 3..MAX_GRID
    assign g_e = GW'(r_grid);
    always_comb begin
        if (g_e < GW'(3)) begin
            g_cl = GW'(3);
        end else if (g_e > GW'(MAX_GRID)) begin
            g_cl = GW'(MAX_GRID);
        end else begin
            g_cl = g_e;
        end
    end
    assign n_eff = g_cl[NW-1:0];

    // Unpack the input word
    assign item = '{cmd:      t_cmd_code'(s_axis_tuser),
                    col:      s_axis_tdata[5:0],
                    row:      s_axis_tdata[11:6],
                    alive_in: s_axis_tdata[12]};
    assign s_axis_tready = idle;
    assign start         = s_axis_tvalid && idle;

    lfa_seq #(.MAX_GRID(MAX_GRID)) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_clear (cfg_wr),
        .i_n         (n_eff),
        .i_start     (start),
        .i_item      (item),
        .o_idle      (idle),
        .o_res_valid (res_valid),
        .i_res_take  (take),
        .o_res       (res)
    );

    // Output register: load when empty or drained
    assign take = res_valid && (!r_mv || m_axis_tready);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
        end else if (take) begin
            r_mv <= 1'b1;
        end else if (m_axis_tready) begin
            r_mv <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_mv;
    assign m_axis_tdata  = {6'b0, r_out.changed_count, r_out.neighbour_count,
                            r_out.cell_alive};
    assign m_axis_tuser  = r_out.out_of_range;

endmodule

// ----- test/life_automaton_torus_test.sv -----
// Self-checking stream testbench for the toroidal life automaton engine.
`timescale 1ns / 1ps

module life_automaton_torus_test;
    import lfa_pkg::*;

    localparam int GRID_MAX   = 64;
    localparam int CELL_TOTAL = GRID_MAX * GRID_MAX;
    localparam int IDLE_LIMIT = 400000;
    localparam int DRAIN_WAIT = 60;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [6:0]  i_cfg_data = '0;

    life_automaton_torus #(.MAX_GRID(GRID_MAX)) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the engine: both cell stores and the wrap size
    logic [CELL_W-1:0] shadow_now  [CELL_TOTAL];
    logic [CELL_W-1:0] shadow_next [CELL_TOTAL];
    int                wrap_size = GRID_MAX;

    t_item   word_queue[$];
    t_result result_queue[$];
    t_item   word_on_bus;
    int      error_count = 0;
    int      snd_idle_pct = 0;
    int      rcv_idle_pct = 0;
    bit      hold_words = 1'b0;

    task automatic report(input string what);
        $display("mismatch: %s", what);
        error_count++;
    endtask

    function automatic void wipe_cells();
        for (int i = 0; i < CELL_TOTAL; i++) begin
            shadow_now[i]  = '0;
            shadow_next[i] = '0;
        end
    endfunction

    function automatic void commit_cells();
        for (int i = 0; i < CELL_TOTAL; i++) shadow_now[i] = shadow_next[i];
    endfunction

    // Flip one cell in the next store and move its neighbours' counts
    function automatic void flip_cell(input int c, input int r, input bit alive);
        int rr, cc, idx;
        logic [CNT_W-1:0] cnt;
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                if (dr != 0 || dc != 0) begin
                    rr  = (r + dr + wrap_size) % wrap_size;
                    cc  = (c + dc + wrap_size) % wrap_size;
                    idx = rr * GRID_MAX + cc;
                    cnt = shadow_next[idx][CNT_W-1:0] + (alive ? 4'd1 : 4'd15);
                    shadow_next[idx] = {shadow_next[idx][CNT_W], cnt};
                end
            end
        end
        shadow_next[r * GRID_MAX + c][CNT_W] = alive;
    endfunction

    // Work out the result word of one accepted command
    function automatic t_result life_result(input t_item it);
        t_result res;
        int idx, changed;
        logic [CELL_W-1:0] v;
        res = '0;
        case (it.cmd)
            CMD_WRITE, CMD_READ: begin
                if (it.col >= wrap_size || it.row >= wrap_size) begin
                    res.out_of_range = 1'b1;
                end else begin
                    idx = it.row * GRID_MAX + it.col;
                    if (it.cmd == CMD_WRITE) begin
                        if (shadow_next[idx][CNT_W] != it.alive_in) begin
                            flip_cell(it.col, it.row, it.alive_in);
                            commit_cells();
                        end
                    end else begin
                        res.cell_alive      = shadow_now[idx][CNT_W];
                        res.neighbour_count = shadow_now[idx][CNT_W-1:0];
                    end
                end
            end
            CMD_STEP: begin
                changed = 0;
                for (int r = 0; r < wrap_size; r++) begin
                    for (int c = 0; c < wrap_size; c++) begin
                        v = shadow_now[r * GRID_MAX + c];
                        if (v[CNT_W] && v[CNT_W-1:0] != CNT_SURVIVE
                                && v[CNT_W-1:0] != CNT_BIRTH) begin
                            flip_cell(c, r, 1'b0);
                            changed++;
                        end else if (!v[CNT_W] && v[CNT_W-1:0] == CNT_BIRTH) begin
                            flip_cell(c, r, 1'b1);
                            changed++;
                        end
                    end
                end
                commit_cells();
                res.changed_count = (changed > 8191) ? 13'd8191 : changed[CHG_W-1:0];
            end
            default: wipe_cells();
        endcase
        return res;
    endfunction

    // Drive command words from the pending queue, predict on acceptance
    always @(posedge i_clk) begin
        t_item nx;
        if (s_axis_tvalid && s_axis_tready) result_queue.push_back(life_result(word_on_bus));
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (!hold_words && word_queue.size() > 0
                    && $urandom_range(0, 99) >= snd_idle_pct) begin
                nx = word_queue.pop_front();
                word_on_bus   = nx;
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {3'b000, nx.alive_in, nx.row, nx.col};
                s_axis_tuser  <= nx.cmd;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Stall the result side at random
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    // Check each result word against the oldest expectation
    always @(posedge i_clk) begin
        t_result want;
        if (m_axis_tvalid && m_axis_tready) begin
            if (result_queue.size() == 0) begin
                report("result word with nothing expected");
            end else begin
                want = result_queue.pop_front();
                if (m_axis_tdata[0] != want.cell_alive)
                    report($sformatf("cell_alive %0d want %0d", m_axis_tdata[0],
                                     want.cell_alive));
                if (m_axis_tdata[4:1] != want.neighbour_count)
                    report($sformatf("neighbour_count %0d want %0d", m_axis_tdata[4:1],
                                     want.neighbour_count));
                if (m_axis_tdata[17:5] != want.changed_count)
                    report($sformatf("changed_count %0d want %0d", m_axis_tdata[17:5],
                                     want.changed_count));
                if (m_axis_tuser[0] != want.out_of_range)
                    report($sformatf("out_of_range %0d want %0d", m_axis_tuser[0],
                                     want.out_of_range));
            end
        end
    end

    // Abort when nothing moves for too long
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("[life_automaton_torus] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic add_word(input t_cmd_code cmd, input int c, input int r, input bit a);
        t_item it;
        it.cmd = cmd;
        it.col = c[COORD_IN_W-1:0];
        it.row = r[COORD_IN_W-1:0];
        it.alive_in = a;
        word_queue.push_back(it);
    endtask

    task automatic wait_drained();
        while (word_queue.size() > 0 || s_axis_tvalid || result_queue.size() > 0)
            @(posedge i_clk);
    endtask

    // Write the grid size once the engine has gone quiet
    task automatic write_size(input int value);
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value[6:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        wrap_size = (value < 3) ? 3 : (value > GRID_MAX) ? GRID_MAX : value;
        wipe_cells();
    endtask

    // Mostly live writes, reads and steps inside the grid, some noise
    task automatic random_words(input int count);
        int pick;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                add_word(CMD_WRITE, $urandom_range(0, wrap_size - 1),
                         $urandom_range(0, wrap_size - 1), $urandom_range(0, 99) < 70);
            else if (pick < 70)
                add_word(CMD_READ, $urandom_range(0, wrap_size - 1),
                         $urandom_range(0, wrap_size - 1), $urandom_range(0, 1));
            else if (pick < 86)
                add_word(CMD_STEP, $urandom_range(0, 63), $urandom_range(0, 63),
                         $urandom_range(0, 1));
            else if (pick < 89)
                add_word(CMD_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63),
                         $urandom_range(0, 1));
            else
                add_word(t_cmd_code'($urandom_range(0, 1)), $urandom_range(0, 63),
                         $urandom_range(0, 63), $urandom_range(0, 1));
        end
    endtask

    initial begin
        wipe_cells();
        snd_idle_pct = 34;
        rcv_idle_pct = 88;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Full-size grid: corners wrap onto each other, no-op write, read, step, clear
        add_word(CMD_WRITE, 0, 0, 1'b1);
        add_word(CMD_WRITE, 63, 63, 1'b1);
        add_word(CMD_WRITE, 0, 0, 1'b1);
        add_word(CMD_READ, 63, 0, 1'b0);
        add_word(CMD_READ, 0, 63, 1'b1);
        add_word(CMD_WRITE, 63, 0, 1'b1);
        add_word(CMD_READ, 0, 0, 1'b0);
        add_word(CMD_STEP, 63, 63, 1'b1);
        add_word(CMD_READ, 63, 63, 1'b0);
        add_word(CMD_WRITE, 63, 63, 1'b0);
        add_word(CMD_CLEAR, 0, 0, 1'b0);
        add_word(CMD_READ, 0, 63, 1'b0);

        // Size below minimum acts as three: dense wrap, out-of-range access, step, clear
        write_size(0);
        add_word(CMD_WRITE, 0, 0, 1'b1);
        add_word(CMD_WRITE, 2, 2, 1'b1);
        add_word(CMD_WRITE, 1, 2, 1'b1);
        add_word(CMD_READ, 1, 1, 1'b0);
        add_word(CMD_WRITE, 3, 1, 1'b1);
        add_word(CMD_READ, 0, 63, 1'b0);
        add_word(CMD_STEP, 0, 0, 1'b0);
        add_word(CMD_READ, 2, 0, 1'b0);
        add_word(CMD_WRITE, 2, 2, 1'b0);
        add_word(CMD_CLEAR, 5, 5, 1'b1);

        // Size above maximum acts as the full grid
        write_size(127);
        random_words(8);

        // Sender idles lightly, receiver heavily; pause for a full drain midway
        snd_idle_pct = 34;
        rcv_idle_pct = 88;
        write_size(6);
        random_words(40);
        while (word_queue.size() > 20) @(posedge i_clk);
        hold_words = 1'b1;
        while (s_axis_tvalid || result_queue.size() > 0) @(posedge i_clk);
        hold_words = 1'b0;

        snd_idle_pct = 88;
        rcv_idle_pct = 34;
        write_size(8);
        random_words(40);

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        write_size(3);
        random_words(30);
        write_size(64);
        random_words(10);

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (result_queue.size() > 0) report("expected results never arrived");
        if (error_count == 0) begin
            $display("[life_automaton_torus] OK");
        end else begin
            $display("[life_automaton_torus] ERROR");
        end
        $finish;
    end

endmodule
